FILE: hdl/nwa_pkg.sv
package nwa_pkg;

  localparam int NWA_NUM_STATES  = 16;
  localparam int NWA_SYMBOL_BITS = 8;

  localparam int OPCODE_W       = 2;
  localparam int STATE_FIELD_W  = 4;
  localparam int SYMBOL_FIELD_W = 8;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [OPCODE_W-1:0] OP_TRANS  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_SYMBOL = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_END    = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_START_STATE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ACCEPT_MASK = 2'd1;

endpackage

FILE: hdl/nwa_if.sv
interface nwa_in_if import nwa_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic [OPCODE_W-1:0]       opcode;
  logic [STATE_FIELD_W-1:0]  from_state;
  logic [STATE_FIELD_W-1:0]  to_state;
  logic [SYMBOL_FIELD_W-1:0] symbol;

  modport source (output valid, opcode, from_state, to_state, symbol, input ready);
  modport sink   (input valid, opcode, from_state, to_state, symbol, output ready);
endinterface

interface nwa_out_if;
  logic valid;
  logic ready;
  logic accepted;

  modport source (output valid, accepted, input ready);
  modport sink   (input valid, accepted, output ready);
endinterface

FILE: hdl/nfa_word_acceptor_top.sv
// A transition beat reads its table row and writes the merged row back; a symbol beat makes
// one table read per state through the single read port. The verdict appears in the output
// register the cycle after the end-of-word beat when the output slot is free; else it is parked.
// Throughput: one beat at a time.
// Reset (rst, synchronous, active high) starts a clearing pass over the transition
// table, NUM_STATES << SYMBOL_BITS rows (4096 by default), before input is taken.
module nfa_word_acceptor_top import nwa_pkg::*; #(
  parameter int NUM_STATES  = NWA_NUM_STATES,
  parameter int SYMBOL_BITS = NWA_SYMBOL_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  nwa_in_if.sink                 item,
  nwa_out_if.source              result
);

  localparam int SW    = $clog2(NUM_STATES);
  localparam int AW    = SW + SYMBOL_BITS;
  localparam int DEPTH = NUM_STATES << SYMBOL_BITS;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_TRANS,
    S_SYM,
    S_HOLD
  } state_t;

  // Transition table: one successor mask per (state, symbol) row.
  logic [NUM_STATES-1:0] table_mem [DEPTH];
  logic [NUM_STATES-1:0] rd_data;
  logic [AW-1:0]         rd_addr;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [NUM_STATES-1:0] wr_data;

  state_t                   state;
  logic [AW-1:0]            clr_addr;
  logic [STATE_FIELD_W-1:0] start_state;
  logic [CFG_DATA_W-1:0]    accept_mask;
  logic [NUM_STATES-1:0]    active;
  logic                     in_word;
  logic [NUM_STATES-1:0]    cur;
  logic [NUM_STATES-1:0]    acc;
  logic [SW-1:0]            st;
  logic [SYMBOL_BITS-1:0]   sym;
  logic [AW-1:0]            tr_addr;
  logic [NUM_STATES-1:0]    tr_bit;
  logic                     pend;
  logic                     out_valid;
  logic                     accepted;

  logic                   beat;
  logic                   out_free;
  logic                   from_ok;
  logic                   to_ok;
  logic [SYMBOL_BITS-1:0] item_sym;
  logic [NUM_STATES-1:0]  start_set;
  logic [NUM_STATES-1:0]  cur_set;
  logic                   word_hit;
  logic [NUM_STATES-1:0]  acc_next;

  assign item.ready      = (state == S_IDLE);
  assign beat            = item.valid && item.ready;
  assign result.valid    = out_valid;
  assign result.accepted = accepted;
  // The output slot can take a new verdict when empty or being drained this cycle.
  assign out_free        = !out_valid || result.ready;

  assign from_ok  = 32'(item.from_state) < NUM_STATES;
  assign to_ok    = 32'(item.to_state) < NUM_STATES;
  assign item_sym = item.symbol[SYMBOL_BITS-1:0];

  // A start state beyond the automaton gives an empty start set.
  assign start_set = (32'(start_state) < NUM_STATES) ?
                     (NUM_STATES'(1) << start_state) : '0;
  // The first symbol of a word, and an empty word, start from the start state.
  assign cur_set   = in_word ? active : start_set;
  // Accept bits above the state count drop out through the size cast.
  assign word_hit  = |(cur_set & NUM_STATES'(accept_mask));

  // Fold in the row returned for state st when that state is active.
  assign acc_next = acc | (cur[st] ? rd_data : '0);

  // Read address: while walking the states, fetch the row one state ahead;
  // otherwise fetch the row the incoming beat needs first.
  always_comb begin
    case (state)
      S_SYM: rd_addr = {SW'(st + SW'(1)), sym};
      default: begin
        if (item.opcode == OP_TRANS) begin
          rd_addr = {SW'(item.from_state), item_sym};
        end else begin
          rd_addr = {SW'(0), item_sym};
        end
      end
    endcase
  end

  // Write port: zero rows during the clearing pass, write back a merged row
  // in S_TRANS, after a transition beat is taken.
  always_comb begin
    case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = '0;
      end
      S_TRANS: begin
        wr_en   = 1'b1;
        wr_addr = tr_addr;
        wr_data = rd_data | tr_bit;
      end
      default: begin
        wr_en   = 1'b0;
        wr_addr = tr_addr;
        wr_data = rd_data | tr_bit;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_data;
    end
    rd_data <= table_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      start_state <= '0;
      accept_mask <= '0;
      active      <= '0;
      in_word     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_START_STATE: start_state <= cfg_data[STATE_FIELD_W-1:0];
          REG_ACCEPT_MASK: accept_mask <= cfg_data;
          default: ;
        endcase
      end

      // Drop the verdict once the sink takes its beat; reloads below win.
      if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (beat) begin
            case (item.opcode)
              OP_TRANS: begin
                // Transitions naming a state outside the automaton are dropped.
                if (from_ok && to_ok) begin
                  tr_addr <= rd_addr;
                  tr_bit  <= NUM_STATES'(1) << item.to_state;
                  state   <= S_TRANS;
                end
              end
              OP_SYMBOL: begin
                cur     <= cur_set;
                in_word <= 1'b1;
                acc     <= '0;
                st      <= '0;
                sym     <= item_sym;
                state   <= S_SYM;
              end
              OP_END: begin
                active  <= '0;
                in_word <= 1'b0;
                if (out_free) begin
                  out_valid <= 1'b1;
                  accepted  <= word_hit;
                end else begin
                  // Output slot still occupied: park the verdict.
                  pend  <= word_hit;
                  state <= S_HOLD;
                end
              end
              default: ;
            endcase
          end
        end

        S_TRANS: begin
          state <= S_IDLE;
        end

        S_SYM: begin
          acc <= acc_next;
          st  <= st + SW'(1);
          if (st == SW'(NUM_STATES - 1)) begin
            active <= acc_next;
            state  <= S_IDLE;
          end
        end

        S_HOLD: begin
          if (result.ready) begin
            out_valid <= 1'b1;
            accepted  <= pend;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/nwa_checker.sv
module nwa_checker import nwa_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic [OPCODE_W-1:0] in_opcode,
  input logic                out_valid,
  input logic                out_ready,
  input logic                out_accepted
);

  // Reset empties the output register.
  a_reset_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // Reset starts the table clear, so no input is taken next cycle.
  a_reset_busy: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("input ready during table clear");

  // A symbol beat occupies the block while the states are walked.
  a_sym_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_opcode == OP_SYMBOL |=> !in_ready)
    else $error("input ready right after a symbol beat");

  // A fresh verdict follows an end-of-word beat directly.
  a_out_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_opcode == OP_END))
    else $error("verdict without end-of-word beat");

  // A stalled verdict holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_accepted))
    else $error("stalled verdict changed");

endmodule

bind nfa_word_acceptor_top nwa_checker u_nwa_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (item.valid),
  .in_ready     (item.ready),
  .in_opcode    (item.opcode),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .out_accepted (result.accepted)
);

FILE: test/nfa_acceptor_sb_pkg.sv
package nfa_acceptor_sb_pkg;
  import nwa_pkg::*;

  localparam int SYM_COUNT = 1 << NWA_SYMBOL_BITS;

  typedef logic [NWA_NUM_STATES-1:0] state_set_t;

  // Set-of-states model of the acceptor plus the queue of verdicts still owed.
  class verdict_board;
    state_set_t               succ [NWA_NUM_STATES][SYM_COUNT];
    state_set_t               active;
    bit                       in_word;
    logic [STATE_FIELD_W-1:0] start_state;
    logic [CFG_DATA_W-1:0]    accept_mask;
    bit                       verdicts [$];
    int                       errors;

    function new();
      foreach (succ[s, c]) succ[s][c] = '0;
      active      = '0;
      in_word     = 1'b0;
      start_state = '0;
      accept_mask = '0;
      errors      = 0;
    endfunction

    function state_set_t start_set();
      state_set_t s;
      s = '0;
      if (int'(start_state) < NWA_NUM_STATES) s[start_state] = 1'b1;
      return s;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_START_STATE: start_state = data[STATE_FIELD_W-1:0];
        REG_ACCEPT_MASK: accept_mask = data;
        default: ;
      endcase
    endfunction

    // Apply one accepted input beat; queue a verdict on end of word.
    function void note_beat(logic [OPCODE_W-1:0] op, logic [STATE_FIELD_W-1:0] from,
                            logic [STATE_FIELD_W-1:0] to, logic [SYMBOL_FIELD_W-1:0] sym);
      state_set_t                 nxt;
      state_set_t                 cur;
      logic [NWA_SYMBOL_BITS-1:0] s;
      s = sym[NWA_SYMBOL_BITS-1:0];
      case (op)
        OP_TRANS: begin
          if (int'(from) < NWA_NUM_STATES && int'(to) < NWA_NUM_STATES)
            succ[from][s][to] = 1'b1;
        end
        OP_SYMBOL: begin
          if (!in_word) begin
            active  = start_set();
            in_word = 1'b1;
          end
          nxt = '0;
          for (int st = 0; st < NWA_NUM_STATES; st++)
            if (active[st]) nxt |= succ[st][s];
          active = nxt;
        end
        OP_END: begin
          cur = in_word ? active : start_set();
          verdicts = {verdicts, bit'(|(cur & accept_mask[NWA_NUM_STATES-1:0]))};
          active  = '0;
          in_word = 1'b0;
        end
        default: ;
      endcase
    endfunction

    function void check_verdict(logic got);
      bit want;
      if (verdicts.size() == 0) begin
        $error("accepted: no result expected, actual %0b", got);
        errors++;
      end else begin
        want = verdicts.pop_front();
        if (got !== want) begin
          $error("accepted: expected %0b, actual %0b", want, got);
          errors++;
        end
      end
    endfunction

    function int pending();
      return verdicts.size();
    endfunction

    function void drain_check();
      if (verdicts.size() != 0) begin
        $error("accepted: %0d result(s) never arrived, oldest expected %0b",
               verdicts.size(), verdicts[0]);
        errors++;
      end
    endfunction
  endclass

endpackage

FILE: test/tb_top.sv
module tb_top;
  import nwa_pkg::*;
  import nfa_acceptor_sb_pkg::*;

  // Opcode and register indexes the block must ignore.
  localparam logic [OPCODE_W-1:0]    OP_UNUSED  = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE3 = 2'd3;

  // Idle cycles tolerated with no beat moving: covers the table clearing pass
  // after reset several times over, plus the longest stalls.
  localparam int WATCHDOG_LIMIT = 20000;
  // Quiet time before a register write: a symbol beat can still be in flight
  // with nothing left to expect.
  localparam int SETTLE_CYCLES  = 2 * (NWA_NUM_STATES + 1) + 8;
  localparam int BEAT_TARGET    = 900;
  // Data bits above the start state field.
  localparam int START_PAD_W    = CFG_DATA_W - STATE_FIELD_W;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  nwa_in_if  item_ch ();
  nwa_out_if result_ch ();

  verdict_board              board;
  bit                        quiet;
  int                        beats_sent;
  logic [SYMBOL_FIELD_W-1:0] alphabet [3];
  logic [STATE_FIELD_W-1:0]  pool [5];

  nfa_word_acceptor_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_ch),
    .result    (result_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly no gap, often a short one, now and then a long one; none when quiet.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(12, 60);
  endfunction

  function automatic logic [STATE_FIELD_W-1:0] rand_state();
    return STATE_FIELD_W'($urandom_range(0, NWA_NUM_STATES - 1));
  endfunction

  function automatic logic [SYMBOL_FIELD_W-1:0] rand_sym();
    return SYMBOL_FIELD_W'($urandom_range(0, 255));
  endfunction

  // Offer one beat after a random gap and hold it until the handshake.
  // Leave valid high afterwards so back-to-back beats need not drop valid between them.
  task automatic send_beat(input logic [OPCODE_W-1:0] op,
                           input logic [STATE_FIELD_W-1:0] from,
                           input logic [STATE_FIELD_W-1:0] to,
                           input logic [SYMBOL_FIELD_W-1:0] sym);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid      <= 1'b1;
    item_ch.opcode     <= op;
    item_ch.from_state <= from;
    item_ch.to_state   <= to;
    item_ch.symbol     <= sym;
    do @(posedge clk); while (!item_ch.ready);
    board.note_beat(op, from, to, sym);
    if (op != OP_UNUSED) beats_sent++;
  endtask

  // Symbol beats carry random state fields, which the block must not use.
  task automatic feed_symbol(input logic [SYMBOL_FIELD_W-1:0] sym);
    send_beat(OP_SYMBOL, rand_state(), rand_state(), sym);
  endtask

  task automatic end_word();
    send_beat(OP_END, rand_state(), rand_state(), rand_sym());
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    board.write_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Drop valid, wait for every owed verdict, then let any symbol beat finish.
  task automatic settle();
    item_ch.valid <= 1'b0;
    while (board.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Result side: check each verdict beat, stall ready at random.
  initial begin
    int stall;
    stall = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (result_ch.valid === 1'b1 && result_ch.ready)
        board.check_verdict(result_ch.accepted);
      if (stall > 0) begin
        stall--;
        result_ch.ready <= 1'b0;
      end else begin
        stall = pick_gap();
        result_ch.ready <= (stall == 0);
      end
    end
  end

  // Watchdog: end the run once no beat has moved on either side for too long.
  initial begin
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((item_ch.valid && item_ch.ready) || (result_ch.valid === 1'b1 && result_ch.ready))
        idle = 0;
      else
        idle++;
    end
    $display("nfa_word_acceptor_top regression: fail");
    $finish;
  end

  initial begin
    int                        phase;
    int                        r;
    int                        n_trans;
    int                        n_words;
    int                        wlen;
    logic [STATE_FIELD_W-1:0]  st;
    logic [CFG_DATA_W-1:0]     mask;
    logic [SYMBOL_FIELD_W-1:0] sym;

    board = new();
    quiet      = 1'b0;
    beats_sent = 0;
    phase      = 0;

    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_index          <= '0;
    cfg_data           <= '0;
    item_ch.valid      <= 1'b0;
    item_ch.opcode     <= '0;
    item_ch.from_state <= '0;
    item_ch.to_state   <= '0;
    item_ch.symbol     <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // --- Directed part ---
    // Empty word under the reset settings: start state 0, nothing accepting.
    end_word();
    settle();

    // Start at the top state (upper data bits must be dropped); accept it alone.
    write_reg(REG_START_STATE, 16'hFFFF);
    write_reg(REG_ACCEPT_MASK, 16'h8000);
    // Empty word, start state accepting.
    end_word();

    // Small automaton over the extreme symbols 8'h00 and 8'hFF.
    send_beat(OP_TRANS, 4'd15, 4'd0,  8'hFF);
    send_beat(OP_TRANS, 4'd0,  4'd15, 8'hFF);
    send_beat(OP_TRANS, 4'd15, 4'd15, 8'h00);
    send_beat(OP_TRANS, 4'd15, 4'd0,  8'h00);
    send_beat(OP_TRANS, 4'd15, 4'd0,  8'h00);   // repeat of an existing edge

    feed_symbol(8'hFF);                         // {0}: rejected
    end_word();
    feed_symbol(8'hFF);                         // {0} then {15}: accepted
    feed_symbol(8'hFF);
    end_word();
    // Missing transition empties the set; it stays empty.
    feed_symbol(8'h55);
    feed_symbol(8'hFF);
    end_word();
    // Nondeterministic branch: {0, 15}, one of them accepting.
    feed_symbol(8'h00);
    // Unused opcode with every field bit set must leave the word alone.
    send_beat(OP_UNUSED, 4'hF, 4'hF, 8'hFF);
    end_word();
    send_beat(OP_UNUSED, 4'h0, 4'h0, 8'h00);
    end_word();                                 // empty word again
    settle();

    // Every state accepting; spare register indexes must be ignored.
    write_reg(REG_START_STATE, 16'h0000);
    write_reg(REG_ACCEPT_MASK, 16'hFFFF);
    write_reg(REG_SPARE2, 16'h0005);
    write_reg(REG_SPARE3, 16'h0000);
    end_word();
    feed_symbol(8'hFF);
    end_word();
    feed_symbol(8'h00);                         // no edge out of state 0 on 8'h00
    end_word();

    // --- Random part: one small automaton per phase, then words over it ---
    while (beats_sent < BEAT_TARGET) begin
      settle();
      case (phase % 4)
        0:       st = '0;
        1:       st = '1;
        default: st = rand_state();
      endcase
      r = $urandom_range(0, 9);
      if (r == 0)
        mask = '0;
      else if (r == 1)
        mask = '1;
      else
        mask = CFG_DATA_W'($urandom_range(0, 65535));
      // Hold the upper data bits random to check they are dropped.
      write_reg(REG_START_STATE,
                {START_PAD_W'($urandom_range(0, (1 << START_PAD_W) - 1)), st});
      write_reg(REG_ACCEPT_MASK, mask);
      if ($urandom_range(0, 5) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE2 : REG_SPARE3,
                  CFG_DATA_W'($urandom_range(0, 65535)));

      quiet = ($urandom_range(0, 3) == 0);
      foreach (alphabet[i]) alphabet[i] = rand_sym();
      pool[0] = st;
      for (int i = 1; i < 5; i++) pool[i] = rand_state();

      n_trans = $urandom_range(6, 14);
      for (int i = 0; i < n_trans; i++)
        send_beat(OP_TRANS, pool[$urandom_range(0, 4)], pool[$urandom_range(0, 4)],
                  alphabet[$urandom_range(0, 2)]);

      n_words = $urandom_range(5, 12);
      for (int w = 0; w < n_words; w++) begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          // Noise: any opcode, any fields.
          send_beat(OPCODE_W'($urandom_range(0, 3)), rand_state(), rand_state(), rand_sym());
        end else begin
          wlen = $urandom_range(0, 6);
          for (int k = 0; k < wlen; k++) begin
            sym = alphabet[$urandom_range(0, 2)];
            // Broken word: a symbol from outside the phase alphabet.
            if (r < 22 && k == wlen - 1) sym = rand_sym();
            feed_symbol(sym);
          end
          end_word();
        end
      end
      phase++;
    end

    settle();
    board.drain_check();
    if (board.errors == 0)
      $display("nfa_word_acceptor_top regression: pass");
    else
      $display("nfa_word_acceptor_top regression: fail");
    $finish;
  end

endmodule
